@@ hw/rtl/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, constants and the result record that travels down the
// cell chain of the sponge distance estimator.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int COORD_W = 32;  // input coordinate width, signed
  localparam int DIST_W  = 31;  // distance width, unsigned
  localparam int LVL_W   = 3;   // holds a level number up to 7
  localparam int AXES    = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // floor(x / 3) == (x * RECIP3) >> 33 for every 32-bit x
  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHR = 33;

  // Result record handed from cell to cell.
  // done      : an outcome is settled (outside the cube or in a hole)
  // shift_cnt : divisions by three still owed on dist_val
  // dist_val  : distance, or hole wall before the divisions
  typedef struct packed {
    logic              done;
    logic [LVL_W-1:0]  shift_cnt;
    logic [DIST_W-1:0] dist_val;
  } mse_res_t;

endpackage

@@ hw/rtl/mse_if.sv @@
// ----------------------------------------------------------------------------
// mse_if
// Valid/ready channels of the sponge distance estimator: one for points,
// one for results.
// ----------------------------------------------------------------------------
interface mse_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [mse_pkg::COORD_W-1:0] coord_x;
  logic signed [mse_pkg::COORD_W-1:0] coord_y;
  logic signed [mse_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

interface mse_result_if;
  logic                        valid;
  logic                        ready;
  logic                        inside_res;
  logic [mse_pkg::DIST_W-1:0]  distance;

  modport source (output valid, output inside_res, output distance, input ready);
  modport sink   (input valid, input inside_res, input distance, output ready);
endinterface

@@ hw/rtl/menger_sponge_distance_estimate.sv @@
// ----------------------------------------------------------------------------
// menger_sponge_distance_estimate
// Distance estimate from a fixed-point point to a Menger sponge of
// SPONGE_ORDER levels, one point per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Takes one point per cycle unless back-pressure stalls the input, and
// returns one result per point, in order. Every point passes through one
// entry stage that shifts the point into the unit cube and measures
// overshoot, SPONGE_ORDER-1 level cells that each extract one base-3 digit
// per axis, and SPONGE_ORDER-1 divide cells that scale a hole wall down by 3
// per cell with rounding up. Each stage holds its own transaction and has
// its own valid bit, so bubbles close up and the input keeps flowing while
// a finished result waits at the output register until every stage fills.
// A point outside the cube reports its smallest overshoot; a point inside
// the solid reports inside_res = 1 and distance 0. Coordinates and
// distance use FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module menger_sponge_distance_estimate #(
  parameter int SPONGE_ORDER = 5,
  parameter int FRAC_BITS    = 24
) (
  input  logic          clk,
  input  logic          rst,
  mse_point_if.sink     point,
  mse_result_if.source  result
);
  import mse_pkg::*;

  localparam int NUM_LVL = SPONGE_ORDER - 1;
  localparam int LAST    = 2 * NUM_LVL;
  localparam int CW      = COORD_W + 1;  // shifted coordinate, signed

  localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HALF_C = CW'(1) << (FRAC_BITS - 1);

  // Stage k register: valid, settled result, and digit residues (level side)
  logic                               stg_valid [0:LAST];
  logic                               stg_ready [0:LAST];
  mse_res_t                           stg_res   [0:LAST];
  logic [AXES-1:0][FRAC_BITS-1:0]     stg_rem   [0:NUM_LVL];

  // ------------------------------------------------------------------
  // Entry stage: shift by one half, check the cube, find overshoot
  // ------------------------------------------------------------------
  logic [AXES-1:0][COORD_W-1:0]   crd;
  logic [AXES-1:0][CW-1:0]        cs;
  logic [AXES-1:0][CW-1:0]        ov;
  logic [AXES-1:0]                outside;
  logic [AXES-1:0][FRAC_BITS-1:0] rem0;
  logic [CW-1:0]                  best;
  logic                           any_out;
  mse_res_t                       res0;

  assign crd[0] = point.coord_x;
  assign crd[1] = point.coord_y;
  assign crd[2] = point.coord_z;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      cs[i]      = {crd[i][COORD_W-1], crd[i]} + HALF_C;
      // negative, or above one (non-negative so an unsigned compare works)
      outside[i] = cs[i][CW-1] | (cs[i] > ONE_C);
      ov[i]      = cs[i][CW-1] ? ('0 - cs[i]) : (cs[i] - ONE_C);
      // inside the cube the residue mod one is the low bits; one itself gives 0
      rem0[i]    = cs[i][FRAC_BITS-1:0];
    end
  end

  always_comb begin
    best = '1;
    for (int i = 0; i < AXES; i++) begin
      if (outside[i] && (ov[i] < best)) begin
        best = ov[i];
      end
    end
  end

  assign any_out = |outside;

  always_comb begin
    res0.done      = any_out;
    res0.shift_cnt = '0;
    res0.dist_val  = '0;
    if (any_out) begin
      // saturate the overshoot at the top of the distance field
      res0.dist_val = (best > {2'b00, DIST_MAX}) ? DIST_MAX : best[DIST_W-1:0];
    end
  end

  assign point.ready = ~stg_valid[0] | stg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (point.ready) begin
      stg_valid[0] <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      stg_res[0] <= res0;
      stg_rem[0] <= rem0;
    end
  end

  // ------------------------------------------------------------------
  // Level cells: level m settles a point that lies in a level-m hole
  // ------------------------------------------------------------------
  for (genvar m = 1; m <= NUM_LVL; m++) begin : g_level
    mse_level_cell #(
      .FRAC_BITS (FRAC_BITS),
      .LEVEL     (m)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[m-1]),
      .in_ready  (stg_ready[m-1]),
      .in_res    (stg_res[m-1]),
      .in_rem    (stg_rem[m-1]),
      .out_valid (stg_valid[m]),
      .out_ready (stg_ready[m]),
      .out_res   (stg_res[m]),
      .out_rem   (stg_rem[m])
    );
  end

  // ------------------------------------------------------------------
  // Divide cells: scale a hole wall by 1/3^m, rounding up
  // ------------------------------------------------------------------
  for (genvar k = NUM_LVL + 1; k <= LAST; k++) begin : g_div
    mse_div_cell u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[k-1]),
      .in_ready  (stg_ready[k-1]),
      .in_res    (stg_res[k-1]),
      .out_valid (stg_valid[k]),
      .out_ready (stg_ready[k]),
      .out_res   (stg_res[k])
    );
  end

  // ------------------------------------------------------------------
  // Output: the last divide cell is the output register
  // ------------------------------------------------------------------
  assign stg_ready[LAST]   = result.ready;
  assign result.valid      = stg_valid[LAST];
  assign result.inside_res = ~stg_res[LAST].done;
  assign result.distance   = stg_res[LAST].dist_val;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_no_out_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_divs_done: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (stg_res[LAST].shift_cnt == '0))
    else $error("result leaves with divisions still owed");

  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.inside_res) |-> (result.distance == '0))
    else $error("inside point with nonzero distance");

  a_outside_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.inside_res) |-> (result.distance != '0))
    else $error("point off the sponge with zero distance");

endmodule

@@ hw/rtl/mse_level_cell.sv @@
// ----------------------------------------------------------------------------
// mse_level_cell
// One subdivision level: triple each axis residue, read the base-3 digit,
// and settle the point if two or more axes sit inside the middle third.
// ----------------------------------------------------------------------------
module mse_level_cell #(
  parameter int FRAC_BITS = 24,
  parameter int LEVEL     = 1
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  mse_pkg::mse_res_t                         in_res,
  input  logic [mse_pkg::AXES-1:0][FRAC_BITS-1:0]   in_rem,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output mse_pkg::mse_res_t                         out_res,
  output logic [mse_pkg::AXES-1:0][FRAC_BITS-1:0]   out_rem
);
  import mse_pkg::*;

  localparam logic [LVL_W-1:0] LEVEL_CODE = LVL_W'(LEVEL);

  logic [AXES-1:0][FRAC_BITS+1:0] tri3;
  logic [AXES-1:0][FRAC_BITS-1:0] rem_next;
  logic [AXES-1:0][FRAC_BITS-1:0] far_wall;
  logic [AXES-1:0][FRAC_BITS-1:0] near_wall;
  logic [AXES-1:0]                hole;
  logic [FRAC_BITS-1:0]           wall;
  logic                           in_hole;
  mse_res_t                       res_next;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      // 3r = 2r + r; top two bits are the digit, the rest the next residue
      tri3[i]      = {1'b0, in_rem[i], 1'b0} + {2'b00, in_rem[i]};
      rem_next[i]  = tri3[i][FRAC_BITS-1:0];
      hole[i]      = (tri3[i][FRAC_BITS+1:FRAC_BITS] == 2'd1) && (rem_next[i] != '0);
      far_wall[i]  = '0 - rem_next[i];
      near_wall[i] = (rem_next[i] < far_wall[i]) ? rem_next[i] : far_wall[i];
    end
  end

  always_comb begin
    wall = '1;
    for (int i = 0; i < AXES; i++) begin
      if (hole[i] && (near_wall[i] < wall)) begin
        wall = near_wall[i];
      end
    end
  end

  assign in_hole = (hole[0] & hole[1]) | (hole[0] & hole[2]) | (hole[1] & hole[2]);

  always_comb begin
    res_next = in_res;
    if (!in_res.done && in_hole) begin
      res_next.done      = 1'b1;
      res_next.shift_cnt = LEVEL_CODE;
      res_next.dist_val  = DIST_W'(wall);
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= res_next;
      out_rem <= rem_next;
    end
  end

endmodule

@@ hw/rtl/mse_div_cell.sv @@
// ----------------------------------------------------------------------------
// mse_div_cell
// One step of the scale-down: while divisions are owed, replace the
// distance by its ceiling third and count one off.
// ----------------------------------------------------------------------------
module mse_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mse_pkg::mse_res_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output mse_pkg::mse_res_t out_res
);
  import mse_pkg::*;

  logic [31:0]  num;
  logic [63:0]  prod;
  mse_res_t     res_next;

  // ceil(d / 3) = floor((d + 2) / 3)
  assign num  = {1'b0, in_res.dist_val} + 32'd2;
  assign prod = {32'd0, num} * {32'd0, RECIP3};

  always_comb begin
    res_next = in_res;
    if (in_res.shift_cnt != '0) begin
      res_next.dist_val  = prod[RECIP3_SHR +: DIST_W];
      res_next.shift_cnt = in_res.shift_cnt - 1'b1;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= res_next;
    end
  end

endmodule

@@ test/sponge_distance_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sponge_distance_checker
// Watches the point and result channels of the sponge distance estimator,
// predicts the distance and inside flag of every accepted point and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sponge_distance_checker #(
  parameter int SPONGE_ORDER = 5,
  parameter int FRAC_BITS    = 24
) (
  input  logic   clk,
  input  logic   rst,
  mse_point_if   point,
  mse_result_if  result,
  output int     mismatch_cnt,
  output int     pending_cnt
);
  import mse_pkg::*;

  typedef struct packed {
    logic              solid;
    logic [DIST_W-1:0] dist_val;
  } sponge_out_t;

  sponge_out_t expected_q[$];
  sponge_out_t oldest;

  function automatic sponge_out_t sponge_distance(logic signed [COORD_W-1:0] x,
                                                  logic signed [COORD_W-1:0] y,
                                                  logic signed [COORD_W-1:0] z);
    longint      one;
    longint      pos [AXES];
    longint      best;
    longint      ov;
    longint      p;
    longint      a;
    longint      w;
    longint      wall;
    longint      d;
    int          holes;
    sponge_out_t res;
    one    = longint'(1) << FRAC_BITS;
    pos[0] = longint'(x) + (one >> 1);
    pos[1] = longint'(y) + (one >> 1);
    pos[2] = longint'(z) + (one >> 1);
    res    = '0;

    // outside the unit cube: smallest overshoot among the axes out of range
    best = -1;
    for (int i = 0; i < AXES; i++) begin
      ov = -1;
      if (pos[i] < 0) ov = -pos[i];
      else if (pos[i] > one) ov = pos[i] - one;
      if (ov >= 0 && (best < 0 || ov < best)) best = ov;
    end
    if (best >= 0) begin
      if (best > longint'(DIST_MAX)) best = longint'(DIST_MAX);
      res.dist_val = best[DIST_W-1:0];
      return res;
    end

    // inside: look for a hole on two or more axes, level by level
    p = 1;
    for (int m = 1; m < SPONGE_ORDER; m++) begin
      p     = p * 3;
      holes = 0;
      wall  = -1;
      for (int i = 0; i < AXES; i++) begin
        a = (pos[i] * p) % (3 * one);
        if (a > one && a < 2 * one) begin
          w = (a - one < 2 * one - a) ? a - one : 2 * one - a;
          holes++;
          if (wall < 0 || w < wall) wall = w;
        end
      end
      if (holes >= 2) begin
        d = (wall + p - 1) / p;  // round up so a hole never reads zero
        if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
        res.dist_val = d[DIST_W-1:0];
        return res;
      end
    end
    res.solid = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with nothing expected: inside_res %b distance %0d",
                   $time, result.inside_res, result.distance);
        end else begin
          oldest = expected_q.pop_front();
          if (result.inside_res !== oldest.solid) begin
            mismatch_cnt++;
            $display("%0t: inside_res expected %b actual %b",
                     $time, oldest.solid, result.inside_res);
          end
          if (result.distance !== oldest.dist_val) begin
            mismatch_cnt++;
            $display("%0t: distance expected %0d actual %0d",
                     $time, oldest.dist_val, result.distance);
          end
        end
      end
      if (point.valid && point.ready)
        expected_q.push_back(sponge_distance(point.coord_x, point.coord_y,
                                             point.coord_z));
    end
    pending_cnt = expected_q.size();
  end

endmodule

@@ test/tb_menger_sponge_distance_estimate.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_menger_sponge_distance_estimate
// Streams points into the sponge distance estimator under several idle and
// stall patterns and lets the checker compare every result it returns.
// ----------------------------------------------------------------------------
module tb_menger_sponge_distance_estimate;
  import mse_pkg::*;

  localparam int     SPONGE_ORDER = 5;
  localparam int     FRAC_BITS    = 24;
  localparam longint ONE          = longint'(1) << FRAC_BITS;
  localparam longint HALF         = ONE / 2;

  // Four random phases of this many points each, after the directed part.
  localparam int ITEMS_PER_PHASE = 420;
  // Receiver hold-off long enough to fill every stage of the pipeline.
  localparam int LONG_HOLD       = 300;
  // Slowest correct run is about 1700 points plus the hold-off; the watchdog
  // sits far beyond that.
  localparam int CYCLE_LIMIT     = 400000;
  // Nine stages at the default order; the final wait covers them with margin.
  localparam int DRAIN_CYCLES    = 20;

  logic clk = 1'b0;
  logic rst;

  int   tx_idle_pct;
  int   rx_stall_pct;
  bit   hold_off_req = 1'b0;
  bit   hold_taken;
  int   hold_left;
  int   cycle_cnt = 0;
  int   mismatch_cnt;
  int   pending_cnt;

  always #10 clk = ~clk;

  mse_point_if  pt ();
  mse_result_if rs ();

  menger_sponge_distance_estimate #(
    .SPONGE_ORDER (SPONGE_ORDER),
    .FRAC_BITS    (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .point  (pt),
    .result (rs)
  );

  sponge_distance_checker #(
    .SPONGE_ORDER (SPONGE_ORDER),
    .FRAC_BITS    (FRAC_BITS)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .point        (pt),
    .result       (rs),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  // Watchdog: end the run if the pipeline never drains.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. Drop ready at random per the stall rate, or hold it low for
  // a long stretch once the stimulus asks; the stretch is counted here so the
  // sender keeps offering points meanwhile. One assignment to ready per edge.
  initial begin
    rs.ready <= 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rs.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD - 1;
        rs.ready <= 1'b0;
      end else begin
        rs.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Map a position in the shifted unit cube back to an input coordinate.
  function automatic logic signed [COORD_W-1:0] at_pos(longint c);
    longint v;
    v = c - HALF;
    return v[COORD_W-1:0];
  endfunction

  // Pick one random coordinate. Most land inside the cube, a good share hug
  // a hole wall at some level (one level past the last checked one too), a
  // few sit on the cube faces, and the rest are raw 32-bit patterns.
  function automatic logic signed [COORD_W-1:0] rand_axis();
    int     r;
    int     lvl;
    longint p;
    longint k;
    r = $urandom_range(99);
    if (r < 55)
      return at_pos(longint'($urandom_range(ONE, 0)));
    if (r < 75) begin
      lvl = $urandom_range(SPONGE_ORDER, 1);
      p   = 1;
      repeat (lvl) p = p * 3;
      k   = longint'($urandom_range(p, 0));
      return at_pos((k * ONE) / p + longint'($urandom_range(8)) - 4);
    end
    if (r < 85) begin
      if ($urandom_range(1))
        return at_pos(longint'($urandom_range(64)) - 32);
      return at_pos(ONE + longint'($urandom_range(64)) - 32);
    end
    return $urandom;
  endfunction

  // Offer one point and hold it until the block takes it; then maybe idle.
  // Valid is lowered only on an idle gap, so back-to-back points keep it high.
  task automatic send_point(logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
    pt.valid   <= 1'b1;
    pt.coord_x <= x;
    pt.coord_y <= y;
    pt.coord_z <= z;
    do @(posedge clk); while (!pt.ready);
    if ($urandom_range(99) < tx_idle_pct) begin
      pt.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Pause the sender until every predicted result has come back. The first
  // edge lets the checker record a point taken on the current edge.
  task automatic wait_drained();
    if (pt.valid) pt.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    rst          <= 1'b1;
    pt.valid     <= 1'b0;
    pt.coord_x   <= '0;
    pt.coord_y   <= '0;
    pt.coord_z   <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed points: cube corners and faces, overshoot by one, the
    // extremes of the coordinate range, holes at the first, second and last
    // checked level, a hole one level too deep to count, walls so close that
    // the rounded-up quotient is one, and alternating bit patterns.
    send_point(at_pos(0), at_pos(0), at_pos(0));
    send_point(at_pos(ONE), at_pos(ONE), at_pos(ONE));
    send_point(at_pos(HALF), at_pos(HALF), at_pos(HALF));
    send_point(at_pos(-1), at_pos(0), at_pos(ONE));
    send_point(at_pos(ONE + 1), at_pos(HALF), at_pos(HALF));
    send_point(at_pos(-5), at_pos(ONE + 3), at_pos(7));
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, at_pos(HALF));
    send_point(at_pos(HALF), 32'sh8000_0000, at_pos(0));
    send_point(at_pos(ONE / 3 + 1), at_pos(HALF), at_pos(0));
    send_point(at_pos(2 * ONE / 3), at_pos(HALF), at_pos(ONE));
    send_point(at_pos(HALF), at_pos(0), at_pos(0));
    send_point(at_pos(ONE / 6), at_pos(ONE / 6), at_pos(0));
    send_point(at_pos(ONE / 54), at_pos(ONE / 54), at_pos(ONE / 54));
    send_point(at_pos(ONE / 162), at_pos(ONE / 162), at_pos(ONE / 162));
    send_point(at_pos(HALF), at_pos(HALF), at_pos(-1));
    send_point(at_pos(ONE / 81 + 1), at_pos(ONE / 81 + 1), at_pos(HALF));
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    send_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both lightly.
    // The long receiver hold-off falls in the first phase, where the sender
    // never idles, so the pipeline fills and backs up onto the input.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 66;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 66;
        end
        default: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 60) hold_off_req = 1'b1;
        send_point(rand_axis(), rand_axis(), rand_axis());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mse_pkg.sv
hw/rtl/mse_if.sv
hw/rtl/mse_level_cell.sv
hw/rtl/mse_div_cell.sv
hw/rtl/menger_sponge_distance_estimate.sv
test/sponge_distance_checker.sv
test/tb_menger_sponge_distance_estimate.sv
